// ===== src/xorshift_range_generator_assert.svh =====
// xorshift_range_generator_assert.svh
// Assertion macros used by the checker file; expects clk and rst_n in scope.
`ifndef XORSHIFT_RANGE_GENERATOR_ASSERT_SVH
`define XORSHIFT_RANGE_GENERATOR_ASSERT_SVH

// Same-cycle implication, masked during reset
`define XRG_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define XRG_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Holds in the cycle after any reset cycle
`define XRG_AST_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/xrg_pkg.sv =====
// xrg_pkg: widths, action codes and the remainder-unit request type.
// No dependencies; imported by every module of the generator.
package xrg_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  // xorshift shift amounts
  localparam int SH_A = 13;
  localparam int SH_B = 17;
  localparam int SH_C = 5;

  localparam logic [WORD_W-1:0] SEED_ONE = WORD_W'(1);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_NEXT  = 2'd1,
    ACT_RANGE = 2'd2
  } xrg_action_t;

  // request to the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } xrg_div_req_t;

  // reply from the shared remainder unit
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] rem;
  } xrg_div_rsp_t;

  // one xorshift step: left 13, right 17, left 5
  function automatic logic [WORD_W-1:0] xrg_advance(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = w;
    x = x ^ (x << SH_A);
    x = x ^ (x >> SH_B);
    x = x ^ (x << SH_C);
    return x;
  endfunction

endpackage

// ===== src/xrg_rem.sv =====
// xrg_rem: restoring remainder unit, one quotient bit per cycle.
// Depends on xrg_pkg.
module xrg_rem
  import xrg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  xrg_div_req_t req,
  output xrg_div_rsp_t rsp
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W-1:0] num_r, num_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] div_r, div_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  // shift in the next dividend bit and subtract when it fits
  assign trial = {rem_r, num_r[WORD_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      cnt_nxt  = CNT_W'(WORD_W - 1);
      busy_nxt = 1'b1;
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[WORD_W-2:0], 1'b0};
      rem_nxt = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      div_r  <= div_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/xorshift_range_generator.sv =====
// xorshift_range_generator: top level, action sequencer and result register.
// Depends on xrg_pkg and xrg_rem (shared remainder unit).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one action per beat:
//   load seed (no result), next word, or bounded draw in [low, high).
//   Result channel (out_valid/out_ready) carries one 32-bit value per
//   next or draw beat; load beats and action code 3 give no result.
//   A load leaves the sequencer idle (ready again next cycle); next and
//   empty range go to ST_DONE, which sets out_valid once the output is free.
//   A non-empty draw makes two passes through the bit-serial remainder
//   unit (threshold, then final reduction), trying k >= 1 generator
//   words in ST_DRAW between the passes.
//   The block accepts one item at a time: in_ready is high only while the
//   sequencer is idle, even while a result waits in the output register.
//   Reset sets the generator word to 1 and empties the result register.
//   If the receiver stalls, the result holds; a further finished result
//   waits in the sequencer until the output register frees up.
module xorshift_range_generator
  import xrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [WORD_W-1:0] in_seed_value,
  input  logic [WORD_W-1:0] in_range_low,
  input  logic [WORD_W-1:0] in_range_high,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_value
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THR,
    ST_DRAW,
    ST_RED,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] span_r, span_nxt;
  logic [WORD_W-1:0] low_r, low_nxt;
  logic [WORD_W-1:0] thr_r, thr_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;

  logic              in_beat;
  logic [WORD_W-1:0] adv_word;
  logic [WORD_W-1:0] in_span;
  xrg_div_req_t      div_req;
  xrg_div_rsp_t      div_rsp;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign adv_word = xrg_advance(word_r);
  assign in_span  = in_range_high - in_range_low;

  // shared remainder unit: threshold pass and final reduction
  xrg_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    span_nxt      = span_r;
    low_nxt       = low_r;
    thr_nxt       = thr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    div_req       = '{start: 1'b0, dividend: '0, divisor: span_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (in_action)
            ACT_LOAD: begin
              word_nxt = (in_seed_value == '0) ? SEED_ONE : in_seed_value;
            end
            ACT_NEXT: begin
              word_nxt  = adv_word;
              res_nxt   = adv_word;
              state_nxt = ST_DONE;
            end
            ACT_RANGE: begin
              if (in_range_high <= in_range_low) begin
                res_nxt   = in_range_low;
                state_nxt = ST_DONE;
              end else begin
                // threshold = (2^32 - span) mod span
                span_nxt  = in_span;
                low_nxt   = in_range_low;
                div_req   = '{start: 1'b1, dividend: '0 - in_span, divisor: in_span};
                state_nxt = ST_THR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_THR: begin
        if (div_rsp.done) begin
          thr_nxt   = div_rsp.rem;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        // one generator word per cycle until one clears the threshold
        word_nxt = adv_word;
        if (adv_word >= thr_r) begin
          div_req   = '{start: 1'b1, dividend: adv_word, divisor: span_r};
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (div_rsp.done) begin
          res_nxt   = low_r + div_rsp.rem;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      word_r      <= SEED_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      word_r      <= word_nxt;
      span_r      <= span_nxt;
      low_r       <= low_nxt;
      thr_r       <= thr_nxt;
      res_r       <= res_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ===== src/xrg_checker.sv =====
// xrg_checker: port-level assertions for xorshift_range_generator, bound to it.
// Depends on xrg_pkg and xorshift_range_generator_assert.svh.
`include "xorshift_range_generator_assert.svh"

module xrg_checker
  import xrg_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_action,
  input logic [WORD_W-1:0] in_range_low,
  input logic [WORD_W-1:0] in_range_high,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_value
);

  logic              beat_next;
  logic              beat_empty;
  logic              beat_busy;
  logic              out_stall;
  logic              empty_ok;
  logic [WORD_W-1:0] low_q1_r;
  logic [WORD_W-1:0] low_q2_r;

  assign beat_next  = in_valid && in_ready && (in_action == ACT_NEXT) && !out_valid;
  assign beat_empty = in_valid && in_ready && (in_action == ACT_RANGE) &&
                      (in_range_high <= in_range_low) && !out_valid;
  assign beat_busy  = in_valid && in_ready &&
                      ((in_action == ACT_NEXT) || (in_action == ACT_RANGE));
  assign out_stall  = out_valid && !out_ready;

  // low bound delayed through low_q1_r and then low_q2_r
  always_ff @(posedge clk) begin
    low_q1_r <= in_range_low;
    low_q2_r <= low_q1_r;
  end

  assign empty_ok = out_valid && (out_value == low_q2_r);

  // result register is empty after reset
  `XRG_AST_RST(a_rst_empty, !out_valid, "out_valid set after reset")

  // a stalled result beat holds its value
  `XRG_AST_NXT(a_out_hold, out_stall, out_valid && $stable(out_value), "stalled result changed")

  // a beat that produces a result keeps the input closed for a while
  `XRG_AST_NXT(a_busy, beat_busy, !in_ready, "input ready right after a result beat")

  // an empty range beat on an idle output returns the low bound
  `XRG_AST_NXT(a_empty, beat_empty, ##1 empty_ok, "empty range result wrong")

  // on an idle output, a next beat raises out_valid from the done state
  `XRG_AST_NXT(a_next_lat, beat_next, ##1 out_valid, "next result late")

endmodule

bind xorshift_range_generator xrg_checker u_xrg_checker (.*);

// ===== dv/xorshift_range_generator_tb.sv =====
// Self-checking testbench for xorshift_range_generator: seed loads, raw words
// and bounded draws, with a directed table first and then random beats.
// Depends on xrg_pkg and the RTL of xorshift_range_generator; needs no files.
`timescale 1ns / 1ps

module xorshift_range_generator_tb;
  import xrg_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1800;
  localparam int DRAIN_EVERY  = 450;
  localparam int TAIL_CYCLES  = 200;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_REPORTS  = 10;

  // one directed beat; 'fixed' means the value is typed in, not predicted
  typedef struct packed {
    logic [1:0]        act;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic              fixed;
    logic [WORD_W-1:0] val;
  } beat_row_t;

  localparam int N_ROWS = 25;
  localparam beat_row_t DIRECTED_BEATS [0:N_ROWS-1] = '{
    // first word after reset
    '{ACT_NEXT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0004_2021},
    // empty ranges: low comes back, word untouched
    '{ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // span of one always gives low but still consumes a word
    '{ACT_RANGE,  32'h0000_0000, 32'h1234_5678, 32'h1234_5679, 1'b1, 32'h1234_5678},
    // unused code with every field set: ignored
    '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // zero seed turns into one
    '{ACT_LOAD,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{ACT_NEXT,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0004_2021},
    '{ACT_LOAD,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_NEXT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    // widest span
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000},
    // span just over 2^31: nearly half the words get rejected
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_0000, 32'h8000_0001, 1'b0, 32'h0000_0000},
    '{ACT_RANGE,  32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0000_0000},
    '{ACT_LOAD,   32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_NEXT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0004_2021},
    '{ACT_LOAD,   32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_NEXT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_000A, 32'h0000_0007, 1'b1, 32'h0000_000A},
    '{ACT_RANGE,  32'h0000_0000, 32'h0000_0005, 32'h0000_03E8, 1'b0, 32'h0000_0000},
    '{ACT_LOAD,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
    '{ACT_RANGE,  32'h5A5A_5A5A, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA},
    '{ACT_NEXT,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action = ACT_LOAD;
  logic [WORD_W-1:0] in_seed_value = '0;
  logic [WORD_W-1:0] in_range_low = '0;
  logic [WORD_W-1:0] in_range_high = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_value;

  // predicted generator word and the values still owed by the block
  logic [WORD_W-1:0] model_word = SEED_ONE;
  logic [WORD_W-1:0] owed_values [$];
  int                fail_count = 0;
  int                burst_left = 0;

  xorshift_range_generator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_seed_value (in_seed_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // xorshift step on the predicted word
  function automatic logic [WORD_W-1:0] step_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w << SH_A);
    t = t ^ (t >> SH_B);
    return t ^ (t << SH_C);
  endfunction

  // Updates the predicted word for one beat; returns 1 when a value is due.
  function automatic bit predict_value(input logic [1:0] act,
                                       input logic [WORD_W-1:0] seed,
                                       input logic [WORD_W-1:0] lo,
                                       input logic [WORD_W-1:0] hi,
                                       output logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] floor_val;
    val = '0;
    case (act)
      ACT_LOAD: begin
        model_word = (seed == '0) ? SEED_ONE : seed;
        return 1'b0;
      end
      ACT_NEXT: begin
        model_word = step_word(model_word);
        val = model_word;
        return 1'b1;
      end
      ACT_RANGE: begin
        if (hi <= lo) begin
          val = lo;
          return 1'b1;
        end
        span = hi - lo;
        // 2^32 mod span: words below this would bias the residues
        floor_val = (WORD_W'(0) - span) % span;
        do begin
          model_word = step_word(model_word);
        end while (model_word < floor_val);
        val = lo + (model_word % span);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drives one beat from the current falling edge, bursts and gaps included.
  task automatic send_beat(input logic [1:0] act, input logic [WORD_W-1:0] seed,
                           input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                           input logic fixed, input logic [WORD_W-1:0] fixed_val);
    int gap;
    logic [WORD_W-1:0] val;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_seed_value <= seed;
    in_range_low  <= lo;
    in_range_high <= hi;
    do @(posedge clk); while (!in_ready);
    if (predict_value(act, seed, lo, hi, val))
      owed_values.push_back(fixed ? fixed_val : val);
    @(negedge clk);
  endtask

  // Drops valid and holds off until every owed value has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (owed_values.size() != 0);
  endtask

  task automatic note_fail(input string what, input logic [WORD_W-1:0] want,
                           input logic [WORD_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Receiver: ready follows a random 32-bit pattern, sometimes fully open
  logic [31:0] ready_pattern = '1;
  int          ready_idx = 0;
  always @(negedge clk) begin
    if (ready_idx == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
      if ($urandom_range(0, 5) == 0) ready_pattern = $urandom & $urandom;
    end
    out_ready <= ready_pattern[ready_idx];
    ready_idx = (ready_idx + 1) % 32;
  end

  // Result check against the oldest owed value
  always @(posedge clk) begin : result_check
    logic [WORD_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_values.size() == 0) begin
        note_fail("unexpected result beat", '0, out_value);
      end else begin
        want = owed_values.pop_front();
        if (out_value !== want) note_fail("value mismatch", want, out_value);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int                sent;
    int                pick;
    logic [1:0]        act;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_beat(DIRECTED_BEATS[i].act, DIRECTED_BEATS[i].seed, DIRECTED_BEATS[i].lo,
                DIRECTED_BEATS[i].hi, DIRECTED_BEATS[i].fixed, DIRECTED_BEATS[i].val);
    drain_results();

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      seed = $urandom;
      lo   = $urandom;
      hi   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        act = ACT_LOAD;
        if ($urandom_range(0, 9) == 0) seed = '0;
      end else if (pick < 45) begin
        act = ACT_NEXT;
      end else if (pick < 96) begin
        act = ACT_RANGE;
        case ($urandom_range(0, 5))
          0: begin  // narrow span
            lo = $urandom_range(0, 32'hFFFF_FF00);
            hi = lo + $urandom_range(1, 255);
          end
          1: ;      // both bounds free, empty about half the time
          2: begin  // empty range
            hi = $urandom_range(0, lo);
          end
          3: begin  // heavy rejection
            lo = $urandom_range(0, 32'h7FFF_FE00);
            hi = lo + 32'h8000_0001 + $urandom_range(0, 255);
          end
          4: begin  // power-of-two span, nothing rejected
            lo = $urandom_range(0, 32'h0FFF_FFFF);
            hi = lo + (32'd1 << $urandom_range(0, 27));
          end
          default: begin  // bounds at the top and bottom
            hi = 32'hFFFF_FFFF - $urandom_range(0, 3);
            lo = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom;
          end
        endcase
      end else begin
        act = ACT_UNUSED;
      end
      send_beat(act, seed, lo, hi, 1'b0, '0);
      if (act != ACT_UNUSED) begin
        sent++;
        if (sent % DRAIN_EVERY == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/xrg_pkg.sv
src/xrg_rem.sv
src/xorshift_range_generator.sv
src/xrg_checker.sv
dv/xorshift_range_generator_tb.sv
